// File: rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLKED(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk_sig, rstn_sig, expr, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) !(expr)) else $error(msg);

`endif

// File: rtl/bpfa_pkg.sv
// Shared constants, codes and control types for the bitmap page frame allocator.
`default_nettype none

package bpfa_pkg;

    // Sizing
    localparam int MAP_WORDS_DEF = 128;
    localparam int WORD_BITS     = 32;
    localparam int BLOCK_SHIFT   = 12;          // 4096-byte blocks
    localparam int OP_W          = 2;
    localparam int ADDR_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int FREE_W        = 25;
    localparam int RSV_W         = 13;
    localparam int BNUM_W        = ADDR_W - BLOCK_SHIFT;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;
    localparam int S_DATA_W      = 40;
    localparam int M_DATA_W      = 64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_MEM  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_LOW = 1'd1;

    // Configuration reset values
    localparam logic [ADDR_W-1:0] MEMORY_BYTES_RST = 32'd16777216;
    localparam logic [RSV_W-1:0]  RESERVED_RST     = 13'd256;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic read;
        logic init_start;
        logic init_step;
        logic modify;
        logic load_out;
    } bpfa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_init;
        logic init_last;
        logic out_free;
    } bpfa_stat_t;

endpackage

`default_nettype wire

// File: rtl/bpfa_ctrl.sv
// Sequencing state machine of the allocator.
`default_nettype none

`include "assert_macros.svh"

module bpfa_ctrl
    import bpfa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire bpfa_stat_t stat,
    output bpfa_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_INIT = 3'd2;
    localparam logic [2:0] ST_MOD  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read       = 1'b1;
                cmd.init_start = stat.is_init;
                state_next     = stat.is_init ? ST_INIT : ST_MOD;
            end
            ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (stat.init_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MOD:
            begin
                cmd.modify = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_CLKED(a_accept_to_read, clk, rst_n, cmd.accept |=> state_reg == ST_READ, "accept must start a read")
    `ASSERT_CLKED(a_mod_to_done, clk, rst_n, state_reg == ST_MOD |=> state_reg == ST_DONE, "modify must end in done")

endmodule

`default_nettype wire

// File: rtl/bpfa_dpath.sv
// Datapath of the allocator: usage map memory, summary vector, counters and result register.
`default_nettype none

`include "assert_macros.svh"

module bpfa_dpath
    import bpfa_pkg::*;
#(
    parameter int MAP_WORDS = MAP_WORDS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bpfa_cmd_t             cmd,
    output bpfa_stat_t                 stat,
    input  wire logic [OP_W-1:0]       in_operation,
    input  wire logic [ADDR_W-1:0]     in_block_address,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [M_DATA_W-1:0]        out_data
);

    localparam int CAP    = MAP_WORDS * WORD_BITS;
    localparam int CNT_W  = $clog2(CAP + 1);
    localparam int WIDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int BIDX_W = WIDX_W + BIT_W;
    localparam int PAD_W  = M_DATA_W - STATUS_W - ADDR_W - FREE_W;

    // Configuration registers
    logic [ADDR_W-1:0] mem_bytes_reg;
    logic [RSV_W-1:0]  rsv_reg;

    // Latched input item
    logic [OP_W-1:0]   op_reg;
    logic [ADDR_W-1:0] baddr_reg;

    // Map storage and summary (1 = word holds a free bit; 0 = word reads all ones)
    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] mem_rd_reg;
    logic [MAP_WORDS-1:0] hasfree_reg;
    logic [MAP_WORDS-1:0] hasfree_next;

    // Counters
    logic [CNT_W-1:0] managed_reg;
    logic [CNT_W-1:0] managed_next;
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] used_next;

    // Work registers
    logic [WIDX_W-1:0]   word_reg;
    logic                found_reg;
    logic [WIDX_W-1:0]   init_w_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [ADDR_W-1:0]   res_addr_reg;

    // Output register
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    // Combinational values
    logic [WIDX_W-1:0]    ff_idx;
    logic                 ff_any;
    logic [BNUM_W-1:0]    blk_num;
    logic [BIDX_W-1:0]    blk_idx;
    logic [WIDX_W-1:0]    blk_word;
    logic [BIT_W-1:0]     blk_bit;
    logic                 in_range;
    logic [WIDX_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] cur_word;
    logic [BIT_W-1:0]     zero_bit;
    logic                 alloc_ok;
    logic                 free_ok;
    logic [WORD_BITS-1:0] alloc_word;
    logic [WORD_BITS-1:0] free_word;
    logic [WORD_BITS-1:0] init_free;
    logic [BNUM_W-1:0]    init_blocks;
    logic [CNT_W-1:0]     init_managed;
    logic [CNT_W-1:0]     init_used;
    logic                 mem_we;
    logic [WIDX_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [CNT_W-1:0]     free_cnt;
    logic [FREE_W-1:0]    free_bytes;
    logic [ADDR_W-1:0]    alloc_addr;

    // Lowest word that still holds a free block
    always_comb
    begin
        ff_idx = '0;
        ff_any = 1'b0;
        for (int w = MAP_WORDS - 1; w >= 0; w--)
        begin
            if (hasfree_reg[w])
            begin
                ff_idx = WIDX_W'(w);
                ff_any = 1'b1;
            end
        end
    end

    // Block addressed by a free
    assign blk_num  = baddr_reg[ADDR_W-1:BLOCK_SHIFT];
    assign blk_idx  = blk_num[BIDX_W-1:0];
    assign blk_word = blk_idx[BIDX_W-1:BIT_W];
    assign blk_bit  = blk_idx[BIT_W-1:0];
    assign in_range = 32'(blk_num) < 32'(managed_reg);
    assign rd_addr  = (op_reg == OP_ALLOC) ? ff_idx : blk_word;

    // Word under modification; a word with no free bit is all ones
    assign cur_word = hasfree_reg[word_reg] ? mem_rd_reg : '1;

    // Lowest clear bit of the word
    always_comb
    begin
        zero_bit = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (!cur_word[j])
            begin
                zero_bit = BIT_W'(j);
            end
        end
    end

    assign alloc_ok   = found_reg && (managed_reg > used_reg);
    assign free_ok    = in_range && cur_word[blk_bit];
    assign alloc_word = cur_word | (WORD_BITS'(1) << zero_bit);
    assign free_word  = cur_word & ~(WORD_BITS'(1) << blk_bit);
    assign alloc_addr = ADDR_W'({word_reg, zero_bit, {BLOCK_SHIFT{1'b0}}});

    // Init sizing: managed = min(memory / block, capacity), used = min(reserved, managed)
    assign init_blocks  = mem_bytes_reg[ADDR_W-1:BLOCK_SHIFT];
    assign init_managed = (32'(init_blocks) > 32'(CAP)) ? CNT_W'(CAP) : CNT_W'(init_blocks);
    assign init_used    = (32'(rsv_reg) < 32'(init_managed)) ? CNT_W'(rsv_reg) : init_managed;

    // Free bits of the word swept by init
    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            init_free[j] = (32'({init_w_reg, BIT_W'(j)}) >= 32'(rsv_reg))
                        && (32'({init_w_reg, BIT_W'(j)}) < 32'(managed_reg));
        end
    end

    // Map write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = word_reg;
        mem_wdata = alloc_word;
        if (cmd.init_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = init_w_reg;
            mem_wdata = ~init_free;
        end
        else if (cmd.modify)
        begin
            if (op_reg == OP_ALLOC)
            begin
                mem_we    = alloc_ok;
                mem_wdata = alloc_word;
            end
            else if (op_reg == OP_FREE)
            begin
                mem_we    = free_ok;
                mem_wdata = free_word;
            end
        end
    end

    // Summary vector and counters
    always_comb
    begin
        hasfree_next = hasfree_reg;
        managed_next = managed_reg;
        used_next    = used_reg;
        if (cmd.init_start)
        begin
            managed_next = init_managed;
            used_next    = init_used;
        end
        if (cmd.init_step)
        begin
            hasfree_next[init_w_reg] = |init_free;
        end
        else if (cmd.modify && (op_reg == OP_ALLOC) && alloc_ok)
        begin
            hasfree_next[word_reg] = ~&alloc_word;
            used_next              = used_reg + CNT_W'(1);
        end
        else if (cmd.modify && (op_reg == OP_FREE) && free_ok)
        begin
            hasfree_next[word_reg] = 1'b1;
            used_next              = used_reg - CNT_W'(1);
        end
    end

    // Free bytes after the operation
    assign free_cnt   = managed_reg - used_reg;
    assign free_bytes = FREE_W'({free_cnt, {BLOCK_SHIFT{1'b0}}});

    // Map memory: one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.read)
        begin
            mem_rd_reg <= map_mem[rd_addr];
        end
    end

    // Control state: configuration, summary, counters, sweep index, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_bytes_reg <= MEMORY_BYTES_RST;
            rsv_reg       <= RESERVED_RST;
            hasfree_reg   <= '0;
            managed_reg   <= CNT_W'(CAP);
            used_reg      <= CNT_W'(CAP);
            init_w_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == CFG_MEMORY_BYTES))
            begin
                mem_bytes_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == CFG_RESERVED_LOW))
            begin
                rsv_reg <= cfg_data[RSV_W-1:0];
            end
            hasfree_reg <= hasfree_next;
            managed_reg <= managed_next;
            used_reg    <= used_next;
            if (cmd.init_start)
            begin
                init_w_reg <= '0;
            end
            else if (cmd.init_step)
            begin
                init_w_reg <= init_w_reg + WIDX_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= in_operation;
            baddr_reg <= in_block_address;
        end
        if (cmd.read)
        begin
            word_reg  <= rd_addr;
            found_reg <= ff_any;
        end
        if (cmd.init_start)
        begin
            res_status_reg <= STAT_DONE;
            res_addr_reg   <= '0;
        end
        else if (cmd.modify)
        begin
            res_status_reg <= STAT_DONE;
            res_addr_reg   <= '0;
            if (op_reg == OP_ALLOC)
            begin
                if (alloc_ok)
                begin
                    res_addr_reg <= alloc_addr;
                end
                else
                begin
                    res_status_reg <= STAT_NO_MEM;
                end
            end
            else if (op_reg == OP_FREE)
            begin
                if (!free_ok)
                begin
                    res_status_reg <= STAT_IGNORED;
                end
            end
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, free_bytes, res_addr_reg, res_status_reg};
        end
    end

    assign stat.is_init   = (op_reg == OP_INIT);
    assign stat.init_last = (init_w_reg == WIDX_W'(MAP_WORDS - 1));
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;

    `ASSERT_NEVER(a_used_le_managed, clk, rst_n, used_reg > managed_reg, "used count above managed count")
    `ASSERT_NEVER(a_managed_le_cap, clk, rst_n, 32'(managed_reg) > 32'(CAP), "managed count above capacity")

endmodule

`default_nettype wire

// File: rtl/bitmap_page_frame_allocator.sv
// Top level of the bitmap first-fit page frame allocator.
// Usage:
//   s_axis carries one request per transaction: operation (allocate, free,
//   reinitialize, no-op) and the byte address of a block to free.
//   m_axis returns one result per request: status, allocated byte address
//   and the free byte count after the operation.
//   cfg writes memory_bytes (index 0) and reserved_low_blocks (index 1);
//   cfg_ready is always high. Write configuration only while idle.
// Operation:
//   Allocate, free and no-op pass through accept, map word read,
//   modify/write and result load; the result load waits until the output
//   register is free. Reinitialize replaces modify/write with a sweep that
//   writes one map word per cycle.
//   The map is a word memory with one write and one registered read port;
//   a per-word summary bit locates the first free word in the same cycle.
// Reset: every block reads as used and all blocks count as managed; no
//   clearing pass is needed. A held result waits in the output register
//   while m_axis_tready is low; the next result is loaded once it leaves.
`default_nettype none

module bitmap_page_frame_allocator
    import bpfa_pkg::*;
#(
    parameter int MAP_WORDS = MAP_WORDS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Request stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [S_DATA_W-1:0]   s_axis_tdata,   // operation[1:0], block_address[33:2]
    // Result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [M_DATA_W-1:0]        m_axis_tdata,   // status[1:0], allocated_address[33:2],
                                                       // free_bytes[58:34]
    // Configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    bpfa_cmd_t  cmd;
    bpfa_stat_t stat;

    assign cfg_ready = 1'b1;

    bpfa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bpfa_dpath #(
        .MAP_WORDS (MAP_WORDS)
    ) u_dpath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .in_operation     (s_axis_tdata[OP_W-1:0]),
        .in_block_address (s_axis_tdata[OP_W+ADDR_W-1:OP_W]),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_data         (m_axis_tdata)
    );

endmodule

`default_nettype wire
